// ----- rtl/core/bdpc_pkg.sv -----
package bdpc_pkg;

  // Pixel width of the RAW stream
  localparam int PIXEL_BITS  = 16;
  localparam int THRESH_BITS = 16;

  // Width at which a neighbour difference is compared with the threshold
  localparam int CMP_BITS  = (PIXEL_BITS > THRESH_BITS) ? PIXEL_BITS : THRESH_BITS;
  // Sum of two pixels, and |2c - a - b|, both fit in one extra bit
  localparam int PAIR_BITS = PIXEL_BITS + 1;
  localparam int GRAD_BITS = PIXEL_BITS + 1;
  // Sum of the four cross neighbours
  localparam int CROSS_BITS = PIXEL_BITS + 2;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CORRECT_MODE = 1'b1;

  // Replacement modes
  localparam logic MODE_MEAN     = 1'b0;
  localparam logic MODE_GRADIENT = 1'b1;

  typedef logic [PIXEL_BITS-1:0]  pix_t;
  typedef logic [THRESH_BITS-1:0] thresh_t;
  typedef logic [PAIR_BITS-1:0]   pair_t;
  typedef logic [GRAD_BITS-1:0]   grad_t;
  typedef logic [CROSS_BITS-1:0]  cross_t;

  // Input word: one window
  typedef struct packed {
    pix_t center;
    pix_t up_left;
    pix_t up;
    pix_t up_right;
    pix_t left;
    pix_t right;
    pix_t down_left;
    pix_t down;
    pix_t down_right;
    logic at_border;
  } bdpc_in_t;

  // Output word
  typedef struct packed {
    pix_t corrected;
    logic defect_found;
  } bdpc_out_t;

  // After detection: defect flag and the four pair sums
  typedef struct packed {
    pix_t  center;
    logic  defect;
    pair_t sum_v;
    pair_t sum_h;
    pair_t sum_l;
    pair_t sum_r;
  } bdpc_s1_t;

  // After gradients
  typedef struct packed {
    pix_t   center;
    logic   defect;
    pair_t  sum_v;
    pair_t  sum_h;
    pair_t  sum_l;
    pair_t  sum_r;
    grad_t  grad_v;
    grad_t  grad_h;
    grad_t  grad_l;
    grad_t  grad_r;
    cross_t sum_cross;
  } bdpc_s2_t;

  // After direction choice
  typedef struct packed {
    pix_t   center;
    logic   defect;
    pair_t  sum_best;
    cross_t sum_cross;
  } bdpc_s3_t;

endpackage

// ----- rtl/core/bdpc_detect.sv -----
module bdpc_detect
  import bdpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  thresh_t  threshold,
  input  logic     in_valid,
  output logic     in_ready,
  input  bdpc_in_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bdpc_s1_t out_data
);

  pix_t       nbr [8];
  logic [7:0] exceed;
  bdpc_s1_t   data_next;

  assign nbr[0] = in_data.up_left;
  assign nbr[1] = in_data.up;
  assign nbr[2] = in_data.up_right;
  assign nbr[3] = in_data.left;
  assign nbr[4] = in_data.right;
  assign nbr[5] = in_data.down_left;
  assign nbr[6] = in_data.down;
  assign nbr[7] = in_data.down_right;

  // Absolute difference to each neighbour against the threshold
  always_comb begin
    pix_t diff;
    for (int i = 0; i < 8; i++) begin
      diff = (nbr[i] > in_data.center) ? (nbr[i] - in_data.center)
                                       : (in_data.center - nbr[i]);
      exceed[i] = CMP_BITS'(diff) > CMP_BITS'(threshold);
    end
  end

  // Defect flag and pair sums for the later stages
  always_comb begin
    data_next.center = in_data.center;
    data_next.defect = !in_data.at_border && (&exceed);
    data_next.sum_v  = PAIR_BITS'(in_data.up) + PAIR_BITS'(in_data.down);
    data_next.sum_h  = PAIR_BITS'(in_data.left) + PAIR_BITS'(in_data.right);
    data_next.sum_l  = PAIR_BITS'(in_data.up_left) + PAIR_BITS'(in_data.down_right);
    data_next.sum_r  = PAIR_BITS'(in_data.up_right) + PAIR_BITS'(in_data.down_left);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

  // A border window never comes out flagged
  a_border_pass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.at_border) |=> (out_valid && !out_data.defect))
    else $error("border window flagged as defective");

endmodule

// ----- rtl/core/bdpc_gradient.sv -----
module bdpc_gradient
  import bdpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  bdpc_s1_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bdpc_s2_t out_data
);

  pair_t    two_c;
  bdpc_s2_t data_next;

  // |2c - (a + b)| for one pair
  function automatic grad_t grad_of(pair_t twice, pair_t pair_sum);
    return (twice >= pair_sum) ? (twice - pair_sum) : (pair_sum - twice);
  endfunction

  assign two_c = {in_data.center, 1'b0};

  always_comb begin
    data_next.center    = in_data.center;
    data_next.defect    = in_data.defect;
    data_next.sum_v     = in_data.sum_v;
    data_next.sum_h     = in_data.sum_h;
    data_next.sum_l     = in_data.sum_l;
    data_next.sum_r     = in_data.sum_r;
    data_next.grad_v    = grad_of(two_c, in_data.sum_v);
    data_next.grad_h    = grad_of(two_c, in_data.sum_h);
    data_next.grad_l    = grad_of(two_c, in_data.sum_l);
    data_next.grad_r    = grad_of(two_c, in_data.sum_r);
    data_next.sum_cross = CROSS_BITS'(in_data.sum_v) + CROSS_BITS'(in_data.sum_h);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/bdpc_choose.sv -----
module bdpc_choose
  import bdpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  bdpc_s2_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bdpc_s3_t out_data
);

  grad_t    grad_a;
  grad_t    grad_b;
  pair_t    sum_a;
  pair_t    sum_b;
  bdpc_s3_t data_next;

  // Smallest gradient, earlier direction wins a tie:
  // vertical vs horizontal, left vs right diagonal, then the two winners
  always_comb begin
    if (in_data.grad_h < in_data.grad_v) begin
      grad_a = in_data.grad_h;
      sum_a  = in_data.sum_h;
    end else begin
      grad_a = in_data.grad_v;
      sum_a  = in_data.sum_v;
    end
    if (in_data.grad_r < in_data.grad_l) begin
      grad_b = in_data.grad_r;
      sum_b  = in_data.sum_r;
    end else begin
      grad_b = in_data.grad_l;
      sum_b  = in_data.sum_l;
    end
    data_next.center    = in_data.center;
    data_next.defect    = in_data.defect;
    data_next.sum_best  = (grad_b < grad_a) ? sum_b : sum_a;
    data_next.sum_cross = in_data.sum_cross;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/bdpc_output.sv -----
module bdpc_output
  import bdpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      correct_mode,
  input  logic      in_valid,
  output logic      in_ready,
  input  bdpc_s3_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bdpc_out_t out_data
);

  cross_t    pair_round;
  pix_t      replacement;
  bdpc_out_t data_next;

  // Rounded pair average or floor of the cross mean
  assign pair_round = CROSS_BITS'(in_data.sum_best) + CROSS_BITS'(1);

  always_comb begin
    if (correct_mode == MODE_MEAN) begin
      replacement = in_data.sum_cross[CROSS_BITS-1:2];
    end else begin
      replacement = pair_round[PIXEL_BITS:1];
    end
    data_next.corrected    = in_data.defect ? replacement : in_data.center;
    data_next.defect_found = in_data.defect;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/bayer_defect_pixel_correct.sv -----
// Defective pixel correction for one Bayer 5x5 window per word. A new word is
// taken on every clock while the stream is not held back by the output:
// four register stages (neighbour differences and pair sums, second-order
// gradients, minimum-gradient choice, replacement and output register) each
// hold a valid bit and stall only when the stage ahead is full, so a held
// output backs the stream up without losing or repeating a word and bubbles
// close up. threshold and correct_mode are written through the cfg channel,
// which is always ready; write them only while no word is in flight.
module bayer_defect_pixel_correct
  import bdpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bdpc_in_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bdpc_out_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THRESH_BITS-1:0]    cfg_data
);

  thresh_t  threshold;
  logic     correct_mode;

  logic     s1_valid, s1_ready;
  logic     s2_valid, s2_ready;
  logic     s3_valid, s3_ready;
  bdpc_s1_t s1_data;
  bdpc_s2_t s2_data;
  bdpc_s3_t s3_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= '0;
      correct_mode <= MODE_GRADIENT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data;
        REG_CORRECT_MODE: correct_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline
  bdpc_detect u_detect (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  bdpc_gradient u_gradient (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  bdpc_choose u_choose (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  bdpc_output u_output (
    .clk          (clk),
    .rst          (rst),
    .correct_mode (correct_mode),
    .in_valid     (s3_valid),
    .in_ready     (s3_ready),
    .in_data      (s3_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  // A sink that takes words never stalls the input
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is taken");

  // The only source of input stall is a held output word
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // An accepted word lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word lost at pipeline entry");

endmodule

// ----- verif/dpc_checker.sv -----
module dpc_checker
  import bdpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  bdpc_in_t                  in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  bdpc_out_t                 out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THRESH_BITS-1:0]    cfg_data,
  output int                        mismatches,
  output int                        pending,
  output int                        windows_seen,
  output int                        replaced
);

  // Shadow copy of the two registers
  thresh_t   threshold;
  logic      correct_mode;

  // Corrected pixels still owed by the block, oldest first
  bdpc_out_t expected_pixels[$];

  int mismatch_count = 0;
  int checked_count  = 0;
  int replaced_count = 0;

  function automatic int pix_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Defect test, then mean or minimum-gradient replacement
  function automatic bdpc_out_t correct_window(input bdpc_in_t w, input thresh_t th,
                                               input logic mode);
    int        c, ul, u, ur, l, r, dl, d, dr, lim;
    int        best, best_sum;
    bdpc_out_t res;
    c   = w.center;
    ul  = w.up_left;
    u   = w.up;
    ur  = w.up_right;
    l   = w.left;
    r   = w.right;
    dl  = w.down_left;
    d   = w.down;
    dr  = w.down_right;
    lim = int'(th);
    res.corrected    = w.center;
    res.defect_found = 1'b0;
    if (w.at_border) return res;
    if (pix_gap(ul, c) <= lim || pix_gap(u, c) <= lim || pix_gap(ur, c) <= lim ||
        pix_gap(l, c) <= lim || pix_gap(r, c) <= lim || pix_gap(dl, c) <= lim ||
        pix_gap(d, c) <= lim || pix_gap(dr, c) <= lim)
      return res;
    res.defect_found = 1'b1;
    if (mode == MODE_MEAN) begin
      res.corrected = pix_t'((u + l + r + d) >> 2);
    end else begin
      // first smallest wins: vertical, horizontal, left diagonal, right diagonal
      best     = pix_gap(2 * c, u + d);
      best_sum = u + d;
      if (pix_gap(2 * c, l + r) < best) begin
        best     = pix_gap(2 * c, l + r);
        best_sum = l + r;
      end
      if (pix_gap(2 * c, ul + dr) < best) begin
        best     = pix_gap(2 * c, ul + dr);
        best_sum = ul + dr;
      end
      if (pix_gap(2 * c, ur + dl) < best) begin
        best_sum = ur + dl;
      end
      res.corrected = pix_t'((best_sum + 1) >> 1);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40)
      $display("%0t: output word %0d, %s: got 0x%0h, expected 0x%0h",
               $realtime, checked_count, what, got, want);
    mismatch_count++;
  endtask

  // Watch all three channels on the clock edge
  always @(posedge clk) begin
    bdpc_out_t want;
    if (rst) begin
      threshold    = '0;
      correct_mode = MODE_GRADIENT;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESHOLD)
          threshold = cfg_data;
        else if (cfg_index == REG_CORRECT_MODE)
          correct_mode = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        want = correct_window(in_data, threshold, correct_mode);
        expected_pixels.push_back(want);
        if (want.defect_found) replaced_count++;
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("word with nothing outstanding", out_data.corrected, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.corrected !== want.corrected)
            report_mismatch("corrected", out_data.corrected, want.corrected);
          if (out_data.defect_found !== want.defect_found)
            report_mismatch("defect_found", out_data.defect_found, want.defect_found);
        end
        checked_count++;
      end
    end
    mismatches   <= mismatch_count;
    pending      <= expected_pixels.size();
    windows_seen <= checked_count;
    replaced     <= replaced_count;
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import bdpc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  logic                      clk;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  bdpc_in_t                  in_data      = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  bdpc_out_t                 out_data;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = REG_THRESHOLD;
  thresh_t                   cfg_data     = '0;

  int   tx_idle_pct   = 10;
  int   rx_idle_pct   = 45;
  logic hold_request  = 1'b0;
  int   settings_used = 0;

  int mismatches, pending, windows_seen, replaced;

  bayer_defect_pixel_correct DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dpc_checker pixel_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .windows_seen (windows_seen),
    .replaced     (replaced)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bdpc_in_t make_window(input int c, input int ul, input int u,
                                           input int ur, input int l, input int r,
                                           input int dl, input int d, input int dr,
                                           input logic border);
    bdpc_in_t w;
    w.center     = pix_t'(c);
    w.up_left    = pix_t'(ul);
    w.up         = pix_t'(u);
    w.up_right   = pix_t'(ur);
    w.left       = pix_t'(l);
    w.right      = pix_t'(r);
    w.down_left  = pix_t'(dl);
    w.down       = pix_t'(d);
    w.down_right = pix_t'(dr);
    w.at_border  = border;
    return w;
  endfunction

  // Value within spread of base, clipped to the pixel range
  function automatic pix_t near_value(input int base, input int spread);
    int offs, v;
    offs = $urandom_range(0, 2 * spread);
    v    = base + offs - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return pix_t'(v);
  endfunction

  function automatic pix_t extreme_pixel();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return pix_t'($urandom);
  endfunction

  // Mostly spikes over a smooth patch, some flat patches, noise and extremes
  function automatic bdpc_in_t random_window();
    bdpc_in_t w;
    pix_t     nb[8];
    int       kind, base, spread, shape;
    kind   = $urandom_range(0, 99);
    base   = $urandom_range(0, 65535);
    spread = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 600);
    foreach (nb[i]) nb[i] = near_value(base, spread);
    shape = $urandom_range(0, 9);
    // order: up_left, up, up_right, left, right, down_left, down, down_right
    if (shape == 0) begin
      foreach (nb[i]) nb[i] = pix_t'(base);
    end else if (shape == 1) begin
      nb[3] = nb[1];
      nb[4] = nb[6];
    end else if (shape == 2) begin
      nb[2] = nb[0];
      nb[5] = nb[7];
    end
    w = make_window(0, nb[0], nb[1], nb[2], nb[3], nb[4], nb[5], nb[6], nb[7],
                    $urandom_range(0, 9) == 0);
    if (kind < 60) begin
      w.center = pix_t'(base + 16'h4000 + $urandom_range(0, 16'h7FFF));
    end else if (kind < 78) begin
      w.center = near_value(base, spread);
    end else if (kind < 90) begin
      w = make_window($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    end else begin
      w = make_window(extreme_pixel(), extreme_pixel(), extreme_pixel(),
                      extreme_pixel(), extreme_pixel(), extreme_pixel(),
                      extreme_pixel(), extreme_pixel(), extreme_pixel(),
                      $urandom_range(0, 3) == 0);
    end
    return w;
  endfunction

  // Offer one window, idling first now and then; valid stays up afterwards
  task automatic send_window(input bdpc_in_t w);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every corrected word is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Both registers, back to back; spare bits of the mode word are noise
  task automatic write_config(input thresh_t th, input logic mode);
    logic [THRESH_BITS-1:0] junk;
    junk = THRESH_BITS'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= th;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_CORRECT_MODE;
    cfg_data  <= {junk[THRESH_BITS-1:1], mode};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: too long with no word moving on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("[bayer_defect_pixel_correct] ERROR");
    $finish;
  end

  initial begin : stimulus
    bdpc_in_t directed[$];
    thresh_t  seg_thresh[6];
    logic     seg_mode[6];

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // hand-picked windows: extremes, border, threshold edge, ties, rounding
    directed.push_back(make_window(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(make_window(65535, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(make_window(0, 65535, 65535, 65535, 65535, 65535, 65535,
                                   65535, 65535, 1'b0));
    directed.push_back(make_window(65535, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    directed.push_back(make_window(1000, 100, 100, 100, 100, 100, 100, 100, 1005, 1'b0));
    directed.push_back(make_window(1000, 100, 100, 100, 100, 100, 100, 100, 1006, 1'b0));
    directed.push_back(make_window(1000, 50, 100, 60, 980, 1010, 60, 100, 50, 1'b0));
    directed.push_back(make_window(1000, 980, 100, 60, 50, 50, 60, 100, 1010, 1'b0));
    directed.push_back(make_window(1000, 50, 100, 980, 50, 50, 1010, 100, 50, 1'b0));
    directed.push_back(make_window(1000, 1020, 100, 60, 980, 1010, 60, 100, 990, 1'b0));
    directed.push_back(make_window(1000, 50, 980, 1020, 50, 50, 990, 1010, 50, 1'b0));
    directed.push_back(make_window(50000, 0, 3, 0, 0, 0, 0, 4, 0, 1'b0));

    for (int m = 0; m < 2; m++) begin
      write_config(16'd5, (m == 0) ? MODE_GRADIENT : MODE_MEAN);
      foreach (directed[i]) send_window(directed[i]);
      drain();
    end

    // random segments, two register settings per idling profile
    seg_thresh[0] = '0;                           seg_mode[0] = MODE_MEAN;
    seg_thresh[1] = thresh_t'($urandom_range(0, 3000));  seg_mode[1] = MODE_GRADIENT;
    seg_thresh[2] = '1;                           seg_mode[2] = MODE_GRADIENT;
    seg_thresh[3] = thresh_t'($urandom_range(0, 16000)); seg_mode[3] = MODE_MEAN;
    seg_thresh[4] = thresh_t'($urandom_range(0, 3000));  seg_mode[4] = MODE_GRADIENT;
    seg_thresh[5] = thresh_t'($urandom_range(0, 200));   seg_mode[5] = MODE_MEAN;

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 45;
        end
        1: begin
          tx_idle_pct = 45;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_config(seg_thresh[seg], seg_mode[seg]);
      // long receiver hold-off while the sender keeps offering
      if (seg == 4) hold_request = 1'b1;
      repeat (130) send_window(random_window());
      drain();
    end

    repeat (16) @(posedge clk);

    $display("covered %0d windows under %0d register settings, %0d of them replaced",
             windows_seen, settings_used, replaced);
    $display("both modes, thresholds 0 and 65535, border, tie, rounding and backpressure");
    if (mismatches == 0)
      $display("[bayer_defect_pixel_correct] OK");
    else
      $display("[bayer_defect_pixel_correct] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_detect.sv
rtl/core/bdpc_gradient.sv
rtl/core/bdpc_choose.sv
rtl/core/bdpc_output.sv
rtl/core/bayer_defect_pixel_correct.sv
verif/dpc_checker.sv
verif/testbench.sv
